// ===== rtl/ocp_pkg.sv =====
// ----------------------------------------------------------------------------
// Overflow-checked power package
// Widths, payload types and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ocp_pkg;

	localparam int DATA_WIDTH = 64;
	localparam int HALF_WIDTH = (DATA_WIDTH + 1) / 2;
	localparam int OPND_WIDTH = 2 * HALF_WIDTH;
	localparam int PROD_WIDTH = 4 * HALF_WIDTH;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] base_value;
		logic [DATA_WIDTH-1:0] exponent;
		logic [DATA_WIDTH-1:0] limit;
		logic                  overflow_in;
	} operands_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] power;
		logic                  overflow_out;
	} result_t;

	typedef struct packed {
		logic load;
		logic mul_start;
		logic sqr_sel;
		logic mul_apply;
		logic sqr_apply;
		logic shift;
		logic capture;
	} dp_cmd_t;

	typedef struct packed {
		logic flag;
		logic exp_zero;
		logic exp_bit0;
		logic exp_high_zero;
		logic mul_done;
	} dp_status_t;

endpackage

// ===== rtl/ocp_mult.sv =====
// ----------------------------------------------------------------------------
// Iterative full-width multiplier
// Forms the double-width product from four half-width partial products,
// one per cycle, and accumulates them into the product register.
// ----------------------------------------------------------------------------
module ocp_mult import ocp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	output logic                  done,
	output logic [PROD_WIDTH-1:0] product
);

	localparam logic [2:0] LAST_PHASE = 3'd4;

	logic [OPND_WIDTH-1:0] a_q;
	logic [OPND_WIDTH-1:0] b_q;
	logic [2:0]            phase_q;
	logic                  run_q;
	logic                  done_q;
	logic                  pv_s1;
	logic [OPND_WIDTH-1:0] pp_s1;
	logic [1:0]            weight_s1;
	logic [PROD_WIDTH-1:0] prod_q;
	logic [HALF_WIDTH-1:0] a_half;
	logic [HALF_WIDTH-1:0] b_half;
	logic [PROD_WIDTH-1:0] pp_wide;
	logic [PROD_WIDTH-1:0] pp_shifted;

	assign a_half  = phase_q[0] ? a_q[OPND_WIDTH-1:HALF_WIDTH] : a_q[HALF_WIDTH-1:0];
	assign b_half  = phase_q[1] ? b_q[OPND_WIDTH-1:HALF_WIDTH] : b_q[HALF_WIDTH-1:0];
	assign pp_wide = PROD_WIDTH'(pp_s1);

	always_comb begin
		case (weight_s1)
			2'd0:    pp_shifted = pp_wide;
			2'd1:    pp_shifted = pp_wide << HALF_WIDTH;
			2'd2:    pp_shifted = pp_wide << (2 * HALF_WIDTH);
			default: pp_shifted = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			phase_q <= '0;
			pv_s1   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= run_q && (phase_q == LAST_PHASE);
			pv_s1  <= run_q && (phase_q != LAST_PHASE);
			if (start) begin
				run_q   <= 1'b1;
				phase_q <= '0;
			end else if (run_q) begin
				if (phase_q == LAST_PHASE) begin
					run_q <= 1'b0;
				end
				phase_q <= phase_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		pp_s1     <= {{HALF_WIDTH{1'b0}}, a_half} * {{HALF_WIDTH{1'b0}}, b_half};
		weight_s1 <= {1'b0, phase_q[0]} + {1'b0, phase_q[1]};
		if (start) begin
			a_q    <= OPND_WIDTH'(a);
			b_q    <= OPND_WIDTH'(b);
			prod_q <= '0;
		end else if (pv_s1) begin
			prod_q <= prod_q + pp_shifted;
		end
	end

	assign done    = done_q;
	assign product = prod_q;

endmodule

// ===== rtl/ocp_datapath.sv =====
// ----------------------------------------------------------------------------
// Overflow-checked power datapath
// Holds the running base, product, exponent and limit, the overflow flags
// and the result register, and shares one multiplier between the checked
// multiply and the squaring.
// ----------------------------------------------------------------------------
module ocp_datapath import ocp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  operands_t  operands,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output result_t    result
);

	logic [DATA_WIDTH-1:0] base_q;
	logic [DATA_WIDTH-1:0] exp_q;
	logic [DATA_WIDTH-1:0] limit_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic                  flag_q;
	logic                  sq_over_q;
	result_t               result_q;
	logic [DATA_WIDTH-1:0] mul_a;
	logic                  mul_done;
	logic [PROD_WIDTH-1:0] product;
	logic                  prod_over;

	assign mul_a = cmd.sqr_sel ? base_q : acc_q;

	ocp_mult u_mult (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.a       (mul_a),
		.b       (base_q),
		.done    (mul_done),
		.product (product)
	);

	// The exact product exceeds the limit when any high bit is set or the
	// low word is above it.
	assign prod_over = (product[PROD_WIDTH-1:DATA_WIDTH] != '0)
		|| (product[DATA_WIDTH-1:0] > limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q    <= 1'b0;
			sq_over_q <= 1'b0;
		end else if (cmd.load) begin
			flag_q    <= operands.overflow_in;
			sq_over_q <= 1'b0;
		end else begin
			if (cmd.mul_apply) begin
				flag_q <= flag_q | sq_over_q | prod_over;
			end
			if (cmd.sqr_apply) begin
				sq_over_q <= sq_over_q | prod_over;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q  <= operands.base_value;
			exp_q   <= operands.exponent;
			limit_q <= operands.limit;
			acc_q   <= DATA_WIDTH'(1);
		end else begin
			if (cmd.mul_apply) begin
				acc_q <= product[DATA_WIDTH-1:0];
			end
			if (cmd.sqr_apply) begin
				base_q <= product[DATA_WIDTH-1:0];
			end
			if (cmd.shift) begin
				exp_q <= exp_q >> 1;
			end
		end
		if (cmd.capture) begin
			result_q.power        <= acc_q;
			result_q.overflow_out <= flag_q;
		end
	end

	assign status.flag          = flag_q;
	assign status.exp_zero      = (exp_q == '0);
	assign status.exp_bit0      = exp_q[0];
	assign status.exp_high_zero = (exp_q[DATA_WIDTH-1:1] == '0);
	assign status.mul_done      = mul_done;
	assign result               = result_q;

endmodule

// ===== rtl/ocp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Overflow-checked power controller
// Sequences the square-and-multiply steps over the exponent bits and runs
// the input and output handshakes.
// ----------------------------------------------------------------------------
module ocp_ctrl import ocp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       operands_valid,
	output logic       operands_stall,
	output logic       result_valid,
	input  logic       result_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_SQ     = 3'd3;
	localparam logic [2:0] ST_SQR    = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !result_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (operands_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.flag || status.exp_zero) begin
					state_d = ST_FINISH;
				end else if (status.exp_bit0) begin
					cmd.mul_start = 1'b1;
					state_d       = ST_MUL;
				end else begin
					state_d = ST_SQ;
				end
			end
			ST_MUL: begin
				if (status.mul_done) begin
					cmd.mul_apply = 1'b1;
					state_d       = ST_SQ;
				end
			end
			ST_SQ: begin
				if (status.flag || status.exp_high_zero) begin
					cmd.shift = 1'b1;
					state_d   = ST_CHECK;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.sqr_sel   = 1'b1;
					state_d       = ST_SQR;
				end
			end
			ST_SQR: begin
				cmd.sqr_sel = 1'b1;
				if (status.mul_done) begin
					cmd.sqr_apply = 1'b1;
					cmd.shift     = 1'b1;
					state_d       = ST_CHECK;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.capture = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign operands_stall = (state_q != ST_IDLE);
	assign result_valid   = out_valid_q;

endmodule

// ===== rtl/overflow_checked_power.sv =====
// ----------------------------------------------------------------------------
// Overflow-checked power
// Raises a base to an exponent by square-and-multiply, low exponent bit
// first, and flags when a product exceeds the given limit.
// ----------------------------------------------------------------------------
// The loop squares for each exponent bit up to the highest set bit and multiplies
// for each set bit, the top bit skipping its squaring; overflow ends the loop early.
// A stalled result holds the block in its finish state. One transfer is taken at a
// time, the next only once the last result is captured; the multiplier is shared,
// and a transfer is taken while a result waits.
// Reset clears the controller and the output valid; no result is pending.
module overflow_checked_power import ocp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  operands_t operands,
	input  logic      operands_valid,
	output logic      operands_stall,
	output result_t   result,
	output logic      result_valid,
	input  logic      result_stall
);

	dp_cmd_t    cmd;
	dp_status_t status;

	ocp_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.operands_valid (operands_valid),
		.operands_stall (operands_stall),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.status         (status),
		.cmd            (cmd)
	);

	ocp_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands),
		.cmd      (cmd),
		.status   (status),
		.result   (result)
	);

	// The multiplier only finishes while an item is in work.
	assert property (@(posedge clk) disable iff (!arst_n)
		status.mul_done |-> operands_stall)
		else $error("multiplier finished while the block was idle");

	// A new result only appears after the block was busy with an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(operands_stall))
		else $error("result appeared without an item in work");

	// An accepted transfer makes the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(operands_valid && !operands_stall) |=> operands_stall)
		else $error("block did not start work after a transfer");

	// A capture never shares a cycle with a multiply start or a load.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> !cmd.mul_start && !cmd.load)
		else $error("capture overlapped other datapath commands");

endmodule
